[hw/rtl/bec_pkg.sv]
`timescale 1ns / 1ps
// shared constants, operation codes and the step program for the balance estimator/controller
// no dependencies; used by balance_estimator_controller_core
package bec_pkg;

    localparam int ATAN_STEPS_DEF = 16;
    localparam int MUL_W          = 25;
    localparam int DIV_W          = 64;

    localparam logic signed [32:0] PI_Q28   = 33'sd843314857;
    localparam logic [24:0]        MICRO    = 25'd1000000;
    localparam logic [35:0]        DEN_TILT = 36'd65536000000;
    localparam logic [35:0]        DEN_INT  = 36'd16000000;

    // register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_WEIGHTS = 3'd1;
    localparam logic [2:0] REG_PID     = 3'd2;
    localparam logic [2:0] REG_STATE   = 3'd3;
    localparam logic [2:0] REG_ILIM    = 3'd4;
    localparam logic [2:0] REG_DZONE   = 3'd5;
    localparam logic [2:0] REG_SHUTOFF = 3'd6;
    localparam logic [2:0] REG_OFFSET  = 3'd7;

    // step operations
    localparam logic [3:0] OP_ATAN  = 4'd0;
    localparam logic [3:0] OP_CLR   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_TOT   = 4'd3;
    localparam logic [3:0] OP_TOU   = 4'd4;
    localparam logic [3:0] OP_UTA   = 4'd5;
    localparam logic [3:0] OP_DIV   = 4'd6;
    localparam logic [3:0] OP_SHAPE = 4'd7;
    localparam logic [3:0] OP_FIN   = 4'd8;

    // step enables
    localparam logic [2:0] G_ALWAYS = 3'd0;
    localparam logic [2:0] G_EST    = 3'd1;
    localparam logic [2:0] G_BLEND  = 3'd2;
    localparam logic [2:0] G_RATE   = 3'd3;
    localparam logic [2:0] G_PID    = 3'd4;
    localparam logic [2:0] G_SS     = 3'd5;

    // multiplicand sources
    localparam logic [3:0] M_A    = 4'd0;
    localparam logic [3:0] M_T    = 4'd1;
    localparam logic [3:0] M_TILT = 4'd2;
    localparam logic [3:0] M_GX   = 4'd3;
    localparam logic [3:0] M_DW   = 4'd4;
    localparam logic [3:0] M_RATE = 4'd5;
    localparam logic [3:0] M_E    = 4'd6;
    localparam logic [3:0] M_INT  = 4'd7;
    localparam logic [3:0] M_X1   = 4'd8;

    // multiplier sources
    localparam logic [3:0] B_MICRO = 4'd0;
    localparam logic [3:0] B_AW    = 4'd1;
    localparam logic [3:0] B_AWC   = 4'd2;
    localparam logic [3:0] B_EL    = 4'd3;
    localparam logic [3:0] B_WW    = 4'd4;
    localparam logic [3:0] B_WWC   = 4'd5;
    localparam logic [3:0] B_KI    = 4'd6;
    localparam logic [3:0] B_KP    = 4'd7;
    localparam logic [3:0] B_NKD   = 4'd8;
    localparam logic [3:0] B_16    = 4'd9;
    localparam logic [3:0] B_NK0   = 4'd10;
    localparam logic [3:0] B_NK1   = 4'd11;
    localparam logic [3:0] B_K2    = 4'd12;
    localparam logic [3:0] B_K3    = 4'd13;

    // divide destinations
    localparam logic [1:0] D_TILT = 2'd0;
    localparam logic [1:0] D_RATE = 2'd1;
    localparam logic [1:0] D_INT  = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] grp;
        logic [3:0] msel;
        logic [3:0] bsel;
        logic [1:0] dsel;
    } instr_t;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic instr_t mk(input logic [3:0] o, input logic [2:0] g,
                                  input logic [3:0] m, input logic [3:0] b,
                                  input logic [1:0] d);
        instr_t r;
        r.op   = o;
        r.grp  = g;
        r.msel = m;
        r.bsel = b;
        r.dsel = d;
        return r;
    endfunction

    // estimator then controller, one step per entry
    function automatic instr_t prog(input logic [5:0] pc);
        instr_t r;
        unique case (pc)
            6'd0:    r = mk(OP_ATAN,  G_EST,   M_A,    B_MICRO, D_TILT);
            6'd1:    r = mk(OP_CLR,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd2:    r = mk(OP_MUL,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd3:    r = mk(OP_TOT,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd4:    r = mk(OP_MUL,   G_BLEND, M_T,    B_AWC,   D_TILT);
            6'd5:    r = mk(OP_TOU,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd6:    r = mk(OP_MUL,   G_BLEND, M_TILT, B_MICRO, D_TILT);
            6'd7:    r = mk(OP_MUL,   G_BLEND, M_GX,   B_EL,    D_TILT);
            6'd8:    r = mk(OP_TOT,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd9:    r = mk(OP_UTA,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd10:   r = mk(OP_MUL,   G_BLEND, M_T,    B_AW,    D_TILT);
            6'd11:   r = mk(OP_DIV,   G_BLEND, M_A,    B_MICRO, D_TILT);
            6'd12:   r = mk(OP_CLR,   G_RATE,  M_A,    B_MICRO, D_RATE);
            6'd13:   r = mk(OP_MUL,   G_RATE,  M_DW,   B_MICRO, D_RATE);
            6'd14:   r = mk(OP_TOT,   G_RATE,  M_A,    B_MICRO, D_RATE);
            6'd15:   r = mk(OP_MUL,   G_RATE,  M_T,    B_WW,    D_RATE);
            6'd16:   r = mk(OP_TOU,   G_RATE,  M_A,    B_MICRO, D_RATE);
            6'd17:   r = mk(OP_MUL,   G_RATE,  M_RATE, B_EL,    D_RATE);
            6'd18:   r = mk(OP_TOT,   G_RATE,  M_A,    B_MICRO, D_RATE);
            6'd19:   r = mk(OP_UTA,   G_RATE,  M_A,    B_MICRO, D_RATE);
            6'd20:   r = mk(OP_MUL,   G_RATE,  M_T,    B_WWC,   D_RATE);
            6'd21:   r = mk(OP_DIV,   G_RATE,  M_A,    B_MICRO, D_RATE);
            6'd22:   r = mk(OP_CLR,   G_PID,   M_A,    B_MICRO, D_INT);
            6'd23:   r = mk(OP_MUL,   G_PID,   M_E,    B_KI,    D_INT);
            6'd24:   r = mk(OP_TOT,   G_PID,   M_A,    B_MICRO, D_INT);
            6'd25:   r = mk(OP_MUL,   G_PID,   M_T,    B_EL,    D_INT);
            6'd26:   r = mk(OP_DIV,   G_PID,   M_A,    B_MICRO, D_INT);
            6'd27:   r = mk(OP_CLR,   G_PID,   M_A,    B_MICRO, D_INT);
            6'd28:   r = mk(OP_MUL,   G_PID,   M_E,    B_KP,    D_INT);
            6'd29:   r = mk(OP_MUL,   G_PID,   M_GX,   B_NKD,   D_INT);
            6'd30:   r = mk(OP_MUL,   G_PID,   M_INT,  B_16,    D_INT);
            6'd31:   r = mk(OP_SHAPE, G_PID,   M_A,    B_MICRO, D_INT);
            6'd32:   r = mk(OP_CLR,   G_SS,    M_A,    B_MICRO, D_TILT);
            6'd33:   r = mk(OP_MUL,   G_SS,    M_X1,   B_NK0,   D_TILT);
            6'd34:   r = mk(OP_MUL,   G_SS,    M_RATE, B_NK1,   D_TILT);
            6'd35:   r = mk(OP_MUL,   G_SS,    M_TILT, B_K2,    D_TILT);
            6'd36:   r = mk(OP_MUL,   G_SS,    M_GX,   B_K3,    D_TILT);
            6'd37:   r = mk(OP_SHAPE, G_SS,    M_A,    B_MICRO, D_TILT);
            default: r = mk(OP_FIN,   G_ALWAYS, M_A,   B_MICRO, D_TILT);
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7fffff;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

[hw/rtl/balance_estimator_controller_core.sv]
`timescale 1ns / 1ps
// balance estimator and controller: cordic tilt, complementary filter, pid or state feedback
// depends on bec_pkg
//
// One sensor item is taken at a time and gives one result item. The item runs through a
// short step program: a cordic atan2 (one rotation per cycle), then products formed by a
// bit-serial shift-add multiplier and quotients from a restoring divider with a write-back
// step; each step is fetched in the fetch state before it runs. Numerical-rate mode with
// PID runs the most steps, and fewer run when the estimator or controller stages are
// switched off; the multiplier and divider steps take most of the time of an item. A new
// item is taken while the previous result still waits on m_tready.
module balance_estimator_controller_core #(
    parameter int ATAN_STEPS = bec_pkg::ATAN_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_y, accel_z, gyro_x, wheel_angle, elapsed_us
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drive, angle_estimate, wheel_rate
    output logic [55:0] m_tdata,
    // angle_ready
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_ATAN  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    // configuration
    logic [3:0]         mode_reg;
    logic [31:0]        fw_reg;
    logic [47:0]        pid_reg;
    logic [63:0]        sg_reg;
    logic [14:0]        ilim_reg;
    logic [14:0]        dz_reg;
    logic [14:0]        sh_reg;
    logic signed [15:0] off_reg;

    // control
    logic [2:0] state_reg;
    logic [5:0] pc_reg;
    logic [6:0] cnt_reg;
    logic [1:0] est_reg;
    logic [1:0] ctl_reg;
    logic       estn_reg;
    logic       blend_reg;
    logic       go_reg;
    logic       zflag_reg;
    logic       neg_reg;
    logic       out_valid_reg;

    // item fields
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;
    logic signed [15:0] gx_reg;
    logic signed [23:0] x1_reg;
    logic [15:0]        el_reg;

    // estimator and controller state
    logic signed [15:0] tilt_reg;
    logic               tvalid_reg;
    logic signed [31:0] integ_reg;
    logic signed [23:0] prev_reg;
    logic signed [23:0] rate_reg;
    logic signed [15:0] held_reg;

    // datapath
    logic signed [15:0] a_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] u_reg;
    logic [63:0]        mc_reg;
    logic [24:0]        mb_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [32:0] cz_reg;
    logic [63:0]        dq_reg;
    logic [35:0]        dr_reg;
    logic [35:0]        dd_reg;

    // result
    logic signed [15:0] out_drive_reg;
    logic signed [15:0] out_angle_reg;
    logic signed [23:0] out_rate_reg;
    logic               out_ready_reg;

    bec_pkg::instr_t ins;
    logic            grp_ok;
    logic            s_acc;
    logic            cfg_wr;
    logic            fin_load;

    logic signed [15:0] kp, ki, kd, k0, k1, k2, k3;
    logic [15:0]        aw, ww;
    logic [16:0]        awc, wwc;
    logic signed [24:0] dw;
    logic signed [16:0] e_val;
    logic signed [63:0] m_val;
    logic [24:0]        b_val;
    logic [35:0]        dsor;
    logic [63:0]        dmag;

    logic signed [33:0] sx, sy;
    logic signed [32:0] tab;
    logic signed [32:0] zsum;
    logic signed [16:0] atan_val;
    logic signed [17:0] adiff;

    logic [36:0]        shifted;
    logic [37:0]        trial;
    logic signed [63:0] q_val;
    logic signed [63:0] isum;
    logic signed [63:0] lim_val;

    logic signed [63:0] shr;
    logic signed [15:0] v_sat;
    logic signed [15:0] dz_s;
    logic signed [15:0] sh_s;
    logic signed [15:0] shaped;
    logic               beyond;
    logic signed [15:0] drive_fin;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rate_reg, out_angle_reg, out_drive_reg};
    assign m_tuser  = out_ready_reg;

    always_comb
    begin
        unique case (paddr[5:3])
            bec_pkg::REG_MODE:    prdata = 64'(mode_reg);
            bec_pkg::REG_WEIGHTS: prdata = 64'(fw_reg);
            bec_pkg::REG_PID:     prdata = 64'(pid_reg);
            bec_pkg::REG_STATE:   prdata = sg_reg;
            bec_pkg::REG_ILIM:    prdata = 64'(ilim_reg);
            bec_pkg::REG_DZONE:   prdata = 64'(dz_reg);
            bec_pkg::REG_SHUTOFF: prdata = 64'(sh_reg);
            bec_pkg::REG_OFFSET:  prdata = 64'(off_reg);
            default:              prdata = '0;
        endcase
    end

    assign kp  = pid_reg[15:0];
    assign ki  = pid_reg[31:16];
    assign kd  = pid_reg[47:32];
    assign k0  = sg_reg[15:0];
    assign k1  = sg_reg[31:16];
    assign k2  = sg_reg[47:32];
    assign k3  = sg_reg[63:48];
    assign aw  = fw_reg[15:0];
    assign ww  = fw_reg[31:16];
    assign awc = 17'h10000 - {1'b0, aw};
    assign wwc = 17'h10000 - {1'b0, ww};
    assign dw  = 25'(x1_reg) - 25'(prev_reg);
    assign e_val = -(17'(tilt_reg));

    assign ins = bec_pkg::prog(pc_reg);

    always_comb
    begin
        unique case (ins.grp)
            bec_pkg::G_ALWAYS: grp_ok = 1'b1;
            bec_pkg::G_EST:    grp_ok = estn_reg;
            bec_pkg::G_BLEND:  grp_ok = blend_reg;
            bec_pkg::G_RATE:   grp_ok = (est_reg == 2'd2) && (el_reg != 16'd0);
            bec_pkg::G_PID:    grp_ok = (ctl_reg == 2'd0) && go_reg;
            bec_pkg::G_SS:     grp_ok = (ctl_reg == 2'd1) && go_reg;
            default:           grp_ok = 1'b0;
        endcase
    end

    // result register loads at the finish step once it is free
    assign fin_load = (state_reg == ST_FETCH) && grp_ok && (ins.op == bec_pkg::OP_FIN)
                      && (!out_valid_reg || m_tready);

    always_comb
    begin
        unique case (ins.msel)
            bec_pkg::M_A:    m_val = 64'(a_reg);
            bec_pkg::M_T:    m_val = t_reg;
            bec_pkg::M_TILT: m_val = 64'(tilt_reg);
            bec_pkg::M_GX:   m_val = 64'(gx_reg);
            bec_pkg::M_DW:   m_val = 64'(dw);
            bec_pkg::M_RATE: m_val = 64'(rate_reg);
            bec_pkg::M_E:    m_val = 64'(e_val);
            bec_pkg::M_INT:  m_val = 64'(integ_reg);
            bec_pkg::M_X1:   m_val = 64'(x1_reg);
            default:         m_val = '0;
        endcase
    end

    always_comb
    begin
        unique case (ins.bsel)
            bec_pkg::B_MICRO: b_val = bec_pkg::MICRO;
            bec_pkg::B_AW:    b_val = 25'(aw);
            bec_pkg::B_AWC:   b_val = 25'(awc);
            bec_pkg::B_EL:    b_val = 25'(el_reg);
            bec_pkg::B_WW:    b_val = 25'(ww);
            bec_pkg::B_WWC:   b_val = 25'(wwc);
            bec_pkg::B_KI:    b_val = 25'(ki);
            bec_pkg::B_KP:    b_val = 25'(kp);
            bec_pkg::B_NKD:   b_val = -(25'(kd));
            bec_pkg::B_16:    b_val = 25'd16;
            bec_pkg::B_NK0:   b_val = -(25'(k0));
            bec_pkg::B_NK1:   b_val = -(25'(k1));
            bec_pkg::B_K2:    b_val = 25'(k2);
            bec_pkg::B_K3:    b_val = 25'(k3);
            default:          b_val = '0;
        endcase
    end

    always_comb
    begin
        unique case (ins.dsel)
            bec_pkg::D_TILT: dsor = bec_pkg::DEN_TILT;
            bec_pkg::D_RATE: dsor = 36'({el_reg, 16'b0});
            bec_pkg::D_INT:  dsor = bec_pkg::DEN_INT;
            default:         dsor = bec_pkg::DEN_INT;
        endcase
    end

    // rounding: half the divisor added to the magnitude
    assign dmag = (acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg)) + 64'(dsor >> 1);

    // cordic rotation
    assign sx       = cx_reg >>> cnt_reg[4:0];
    assign sy       = cy_reg >>> cnt_reg[4:0];
    assign tab      = 33'(bec_pkg::atan_entry(cnt_reg[4:0]));
    assign zsum     = cz_reg + 33'sd32768;
    assign atan_val = zflag_reg ? 17'sd0 : 17'(zsum >>> 16);
    assign adiff    = 18'(atan_val) - 18'(off_reg);

    // restoring division, one quotient bit a cycle
    assign shifted = {dr_reg, dq_reg[63]};
    assign trial   = {1'b0, shifted} - {2'b0, dd_reg};
    assign q_val   = neg_reg ? -$signed(dq_reg) : $signed(dq_reg);
    assign isum    = 64'(integ_reg) + q_val;
    assign lim_val = 64'({ilim_reg, 8'b0});

    // drive shaping
    assign shr    = (acc_reg + 64'sd2048) >>> 12;
    assign v_sat  = bec_pkg::sat16(shr);
    assign dz_s   = 16'(dz_reg);
    assign sh_s   = 16'(sh_reg);
    assign beyond = (tilt_reg > sh_s) || (tilt_reg < -sh_s);
    assign shaped = (beyond || ((v_sat > -dz_s) && (v_sat < dz_s))) ? 16'sd0 : v_sat;
    assign drive_fin = (!ctl_reg[1] && !go_reg) ? 16'sd0 : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            fw_reg    <= '0;
            pid_reg   <= '0;
            sg_reg    <= '0;
            ilim_reg  <= '0;
            dz_reg    <= '0;
            sh_reg    <= 15'd2048;
            off_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                bec_pkg::REG_MODE:    mode_reg <= pwdata[3:0];
                bec_pkg::REG_WEIGHTS: fw_reg   <= pwdata[31:0];
                bec_pkg::REG_PID:     pid_reg  <= pwdata[47:0];
                bec_pkg::REG_STATE:   sg_reg   <= pwdata;
                bec_pkg::REG_ILIM:    ilim_reg <= pwdata[14:0];
                bec_pkg::REG_DZONE:   dz_reg   <= pwdata[14:0];
                bec_pkg::REG_SHUTOFF: sh_reg   <= pwdata[14:0];
                bec_pkg::REG_OFFSET:  off_reg  <= pwdata[15:0];
                default:              mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            est_reg       <= '0;
            ctl_reg       <= '0;
            estn_reg      <= 1'b0;
            blend_reg     <= 1'b0;
            go_reg        <= 1'b0;
            zflag_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            tilt_reg      <= '0;
            tvalid_reg    <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            rate_reg      <= '0;
            held_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !fin_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        ay_reg    <= s_tdata[15:0];
                        az_reg    <= s_tdata[31:16];
                        gx_reg    <= s_tdata[47:32];
                        x1_reg    <= s_tdata[71:48];
                        el_reg    <= s_tdata[87:72];
                        est_reg   <= mode_reg[3:2];
                        ctl_reg   <= mode_reg[1:0];
                        estn_reg  <= !mode_reg[2];
                        blend_reg <= !mode_reg[2] && tvalid_reg;
                        go_reg    <= !mode_reg[2] || tvalid_reg;
                        pc_reg    <= '0;
                        state_reg <= ST_FETCH;
                    end
                end

                ST_FETCH:
                begin
                    if (!grp_ok)
                        pc_reg <= pc_reg + 6'd1;
                    else
                    begin
                        case (ins.op)
                            bec_pkg::OP_ATAN:
                            begin
                                zflag_reg <= (ay_reg == 16'sd0) && (az_reg == 16'sd0);
                                cnt_reg   <= '0;
                                if (az_reg < 16'sd0)
                                begin
                                    cx_reg <= -{{4{az_reg[15]}}, az_reg, 14'b0};
                                    cy_reg <= -{{4{ay_reg[15]}}, ay_reg, 14'b0};
                                    cz_reg <= (ay_reg >= 16'sd0) ? bec_pkg::PI_Q28
                                                                 : -bec_pkg::PI_Q28;
                                end
                                else
                                begin
                                    cx_reg <= {{4{az_reg[15]}}, az_reg, 14'b0};
                                    cy_reg <= {{4{ay_reg[15]}}, ay_reg, 14'b0};
                                    cz_reg <= '0;
                                end
                                state_reg <= ST_ATAN;
                            end
                            bec_pkg::OP_CLR:
                            begin
                                acc_reg <= '0;
                                pc_reg  <= pc_reg + 6'd1;
                            end
                            bec_pkg::OP_MUL:
                            begin
                                mc_reg    <= m_val;
                                mb_reg    <= b_val;
                                cnt_reg   <= '0;
                                state_reg <= ST_MUL;
                            end
                            bec_pkg::OP_TOT:
                            begin
                                t_reg   <= acc_reg;
                                acc_reg <= '0;
                                pc_reg  <= pc_reg + 6'd1;
                            end
                            bec_pkg::OP_TOU:
                            begin
                                u_reg   <= acc_reg;
                                acc_reg <= '0;
                                pc_reg  <= pc_reg + 6'd1;
                            end
                            bec_pkg::OP_UTA:
                            begin
                                acc_reg <= u_reg;
                                pc_reg  <= pc_reg + 6'd1;
                            end
                            bec_pkg::OP_DIV:
                            begin
                                neg_reg   <= acc_reg[63];
                                dq_reg    <= dmag;
                                dr_reg    <= '0;
                                dd_reg    <= dsor;
                                cnt_reg   <= '0;
                                state_reg <= ST_DIV;
                            end
                            bec_pkg::OP_SHAPE:
                            begin
                                held_reg <= shaped;
                                if (beyond && (ctl_reg == 2'd0))
                                    integ_reg <= '0;
                                pc_reg <= pc_reg + 6'd1;
                            end
                            default:
                            begin
                                // finish: wait for the result register to be free
                                if (!out_valid_reg || m_tready)
                                begin
                                    held_reg      <= drive_fin;
                                    out_drive_reg <= drive_fin;
                                    out_angle_reg <= tilt_reg;
                                    out_rate_reg  <= rate_reg;
                                    out_ready_reg <= tvalid_reg;
                                    out_valid_reg <= 1'b1;
                                    if (est_reg == 2'd2)
                                        prev_reg <= x1_reg;
                                    state_reg <= ST_IDLE;
                                end
                            end
                        endcase
                    end
                end

                ST_ATAN:
                begin
                    if (cnt_reg == 7'(ATAN_STEPS))
                    begin
                        a_reg <= bec_pkg::sat16(64'(adiff));
                        if (!blend_reg)
                        begin
                            // first sample sets the angle directly
                            tilt_reg   <= bec_pkg::sat16(64'(adiff));
                            tvalid_reg <= 1'b1;
                        end
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        if (cy_reg > 34'sd0)
                        begin
                            cx_reg <= cx_reg + sy;
                            cy_reg <= cy_reg - sx;
                            cz_reg <= cz_reg + tab;
                        end
                        else
                        begin
                            cx_reg <= cx_reg - sy;
                            cy_reg <= cy_reg + sx;
                            cz_reg <= cz_reg - tab;
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end

                ST_MUL:
                begin
                    // top multiplier bit carries negative weight
                    if (mb_reg[0])
                    begin
                        if (cnt_reg == 7'(bec_pkg::MUL_W - 1))
                            acc_reg <= acc_reg - mc_reg;
                        else
                            acc_reg <= acc_reg + mc_reg;
                    end
                    mc_reg <= {mc_reg[62:0], 1'b0};
                    mb_reg <= {1'b0, mb_reg[24:1]};
                    if (cnt_reg == 7'(bec_pkg::MUL_W - 1))
                    begin
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= ST_FETCH;
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end

                ST_DIV:
                begin
                    if (!trial[37])
                    begin
                        dr_reg <= trial[35:0];
                        dq_reg <= {dq_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= shifted[35:0];
                        dq_reg <= {dq_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 7'(bec_pkg::DIV_W - 1))
                        state_reg <= ST_WB;
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end

                ST_WB:
                begin
                    case (ins.dsel)
                        bec_pkg::D_TILT: tilt_reg <= bec_pkg::sat16(q_val);
                        bec_pkg::D_RATE: rate_reg <= bec_pkg::sat24(q_val);
                        default:
                        begin
                            if (isum > lim_val)
                                integ_reg <= lim_val[31:0];
                            else if (isum < -lim_val)
                                integ_reg <= 32'(-lim_val);
                            else
                                integ_reg <= isum[31:0];
                        end
                    endcase
                    pc_reg    <= pc_reg + 6'd1;
                    state_reg <= ST_FETCH;
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FETCH && $past(ins.op) == bec_pkg::OP_FIN)
        else $error("result loaded outside the finish step");

    a_tilt_valid_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg |=> tvalid_reg)
        else $error("angle ready flag dropped");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> cnt_reg < 7'(bec_pkg::MUL_W))
        else $error("multiplier count overrun");

endmodule

[bench/tb_balance_estimator_controller_core.sv]
`timescale 1ns / 1ps
// self-checking bench for balance_estimator_controller_core: stream items in, results checked
// against an in-bench model of the estimator and controller; depends on bec_pkg and the core
module tb_balance_estimator_controller_core;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 36;

    typedef struct {
        logic signed [15:0] drive;
        logic signed [15:0] angle;
        logic signed [23:0] rate;
        logic               ready;
    } balance_out_t;

    typedef struct {
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [23:0] wheel;
        logic [15:0]        el;
        bit                 typed;
        balance_out_t       want;
    } sample_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // accel_y, accel_z, gyro_x, wheel_angle, elapsed_us
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // drive, angle_estimate, wheel_rate
    logic [55:0] m_tdata;
    // angle_ready
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    balance_estimator_controller_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // register copies
    logic [3:0]         mode_r;
    logic [31:0]        weights_r;
    logic [47:0]        pid_r;
    logic [63:0]        ss_gains_r;
    logic [14:0]        ilim_r;
    logic [14:0]        dzone_r;
    logic [14:0]        shutoff_r;
    logic signed [15:0] offset_r;

    // estimator and controller state
    longint tilt_q, integ_q, prev_wheel_q, rate_q, held_drive_q;
    bit     tilt_ready_q;

    balance_out_t pending_results[$];
    int  errors = 0;
    bit  hold_off_req = 1'b0;
    bit  no_idle;
    int  quiet_cycles = 0;

    longint atan_q28[24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clip(input longint v, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // nearest, ties away from zero
    function automatic longint div_round(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint accel_tilt(input longint ay, input longint az);
        longint x, y, z, nx, ny;
        x = az * 16384;
        y = ay * 16384;
        z = 0;
        if (ay == 0 && az == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 843314857 : -843314857;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < bec_pkg::ATAN_STEPS_DEF && i < 24; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_q28[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_q28[i];
            end
            x = nx;
            y = ny;
        end
        return (z + 32768) >>> 16;
    endfunction

    function automatic longint shape_drive(input longint acc);
        longint v, dz;
        v = clip((acc + 2048) >>> 12, 16);
        dz = longint'(dzone_r);
        if (v > -dz && v < dz)
            v = 0;
        return v;
    endfunction

    function automatic balance_out_t balance_step(input sample_row_t s);
        balance_out_t r;
        longint ay, az, gx, x1, el, a, aw, ww, num, drive, sh, e, lim, acc;
        longint kp, ki, kd, k0, k1, k2, k3;
        logic [1:0] est, ctl;
        ay = s.ay;
        az = s.az;
        gx = s.gx;
        x1 = s.wheel;
        el = longint'(s.el);
        est = mode_r[3:2];
        ctl = mode_r[1:0];
        drive = held_drive_q;
        sh = longint'(shutoff_r);
        if (est == 2'd0 || est == 2'd2)
        begin
            a = clip(accel_tilt(ay, az) - longint'(offset_r), 16);
            if (tilt_ready_q)
            begin
                aw = longint'(weights_r[15:0]);
                num = aw * (tilt_q * 1000000 + gx * el) + (65536 - aw) * a * 1000000;
                tilt_q = clip(div_round(num, 64'd65536000000), 16);
            end
            else
            begin
                tilt_q = a;
                tilt_ready_q = 1'b1;
            end
        end
        if (est == 2'd2)
        begin
            if (el != 0)
            begin
                ww = longint'(weights_r[31:16]);
                num = ww * (x1 - prev_wheel_q) * 1000000 + (65536 - ww) * rate_q * el;
                rate_q = clip(div_round(num, 65536 * el), 24);
            end
            prev_wheel_q = x1;
        end
        if (ctl == 2'd0 || ctl == 2'd1)
        begin
            if (!tilt_ready_q)
                drive = 0;
            else if (ctl == 2'd0)
            begin
                kp = longint'($signed(pid_r[15:0]));
                ki = longint'($signed(pid_r[31:16]));
                kd = longint'($signed(pid_r[47:32]));
                e = -tilt_q;
                lim = longint'(ilim_r) * 256;
                acc = integ_q + div_round(e * ki * el, 16000000);
                if (acc > lim)
                    acc = lim;
                else if (acc < -lim)
                    acc = -lim;
                integ_q = acc;
                drive = shape_drive(kp * e - kd * gx + integ_q * 16);
                if (tilt_q > sh || tilt_q < -sh)
                begin
                    drive = 0;
                    integ_q = 0;
                end
            end
            else
            begin
                k0 = longint'($signed(ss_gains_r[15:0]));
                k1 = longint'($signed(ss_gains_r[31:16]));
                k2 = longint'($signed(ss_gains_r[47:32]));
                k3 = longint'($signed(ss_gains_r[63:48]));
                drive = shape_drive(-(k0 * x1 + k1 * rate_q - k2 * tilt_q - k3 * gx));
                if (tilt_q > sh || tilt_q < -sh)
                    drive = 0;
            end
        end
        held_drive_q = drive;
        r.drive = drive[15:0];
        r.angle = tilt_q[15:0];
        r.rate  = rate_q[23:0];
        r.ready = tilt_ready_q;
        return r;
    endfunction

    // leaves the bus in the access phase; the caller idles it after the last write
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        case (idx)
            bec_pkg::REG_MODE:    mode_r     = value[3:0];
            bec_pkg::REG_WEIGHTS: weights_r  = value[31:0];
            bec_pkg::REG_PID:     pid_r      = value[47:0];
            bec_pkg::REG_STATE:   ss_gains_r = value;
            bec_pkg::REG_ILIM:    ilim_r     = value[14:0];
            bec_pkg::REG_DZONE:   dzone_r    = value[14:0];
            bec_pkg::REG_SHUTOFF: shutoff_r  = value[14:0];
            bec_pkg::REG_OFFSET:  offset_r   = value[15:0];
            default:              ;
        endcase
    endtask

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_sample(input sample_row_t s);
        balance_out_t r;
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.el, s.wheel, s.gx, s.az, s.ay};
        do
            @(posedge clk);
        while (!s_tready);
        r = balance_step(s);
        pending_results.push_back(s.typed ? s.want : r);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [15:0] gain16();
        logic [15:0] g;
        g = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) == 1)
            g = -g;
        return g;
    endfunction

    function automatic sample_row_t random_sample();
        sample_row_t s;
        s.typed = 1'b0;
        s.want  = '{default: '0};
        if ($urandom_range(0, 9) < 7)
        begin
            // near upright
            s.az    = 16'($urandom_range(8000, 16384));
            s.ay    = 16'($urandom_range(0, 6000)) - 16'sd3000;
            s.gx    = 16'($urandom_range(0, 4000)) - 16'sd2000;
            s.wheel = 24'($urandom_range(0, 200000)) - 24'sd100000;
            case ($urandom_range(0, 7))
                0:       s.el = 16'd0;
                1:       s.el = 16'hffff;
                default: s.el = 16'($urandom_range(1000, 20000));
            endcase
        end
        else
        begin
            s.ay    = 16'($urandom);
            s.az    = 16'($urandom);
            s.gx    = 16'($urandom);
            s.wheel = 24'($urandom);
            s.el    = 16'($urandom);
        end
        return s;
    endfunction

    sample_row_t directed_rows[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 24'sd0, 16'd1000, 1'b1,
          '{16'sd0, 16'sd0, 24'sd0, 1'b1}},
        '{16'sd32767, 16'sd0, 16'sd0, 24'sd0, 16'd1000, 1'b0, '{default: '0}},
        '{-16'sd32768, 16'sd0, 16'sd0, 24'sd0, 16'd1000, 1'b0, '{default: '0}},
        '{16'sd0, -16'sd32768, 16'sd0, 24'sd0, 16'd1000, 1'b0, '{default: '0}},
        '{16'sd100, -16'sd32768, 16'sd0, 24'sd0, 16'd1000, 1'b0, '{default: '0}},
        '{-16'sd100, -16'sd32768, 16'sd0, 24'sd0, 16'd1000, 1'b0, '{default: '0}},
        '{16'sd0, 16'sd32767, 16'sd32767, 24'sd8388607, 16'hffff, 1'b0, '{default: '0}},
        '{16'sd32767, 16'sd32767, -16'sd32768, -24'sd8388608, 16'hffff, 1'b0,
          '{default: '0}},
        '{-16'sd32768, -16'sd32768, 16'sd32767, 24'sd8388607, 16'd0, 1'b0,
          '{default: '0}},
        '{16'sd500, 16'sd16000, -16'sd300, -24'sd8388608, 16'd0, 1'b0, '{default: '0}},
        '{16'sd0, 16'sd0, 16'sd100, 24'sd4096, 16'd5000, 1'b0, '{default: '0}},
        '{-16'sd1, 16'sd16384, 16'sd0, 24'sd0, 16'd1, 1'b0, '{default: '0}}
    };

    // result side
    initial
    begin
        balance_out_t got, want;
        int n;
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            got.drive = m_tdata[15:0];
            got.angle = m_tdata[31:16];
            got.rate  = m_tdata[55:32];
            got.ready = m_tuser[0];
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.drive !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d", want.drive, got.drive);
                    errors++;
                end
                if (got.angle !== want.angle)
                begin
                    $error("angle_estimate: expected %0d, got %0d", want.angle, got.angle);
                    errors++;
                end
                if (got.rate !== want.rate)
                begin
                    $error("wheel_rate: expected %0d, got %0d", want.rate, got.rate);
                    errors++;
                end
                if (got.ready !== want.ready)
                begin
                    $error("angle_ready: expected %0d, got %0d", want.ready, got.ready);
                    errors++;
                end
            end
        end
    end

    // counts cycles with no item taken on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] w_lo, w_hi;
        no_idle      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mode_r = '0; weights_r = '0; pid_r = '0; ss_gains_r = '0;
        ilim_r = '0; dzone_r = '0; shutoff_r = 15'd2048; offset_r = '0;
        tilt_q = 0; integ_q = 0; prev_wheel_q = 0; rate_q = 0; held_drive_q = 0;
        tilt_ready_q = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i]);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            w_lo = (p == 1) ? 16'hffff : (p == 2) ? 16'h0000 : 16'($urandom);
            w_hi = (p == 1) ? 16'hffff : (p == 2) ? 16'h0000 : 16'($urandom);
            reg_write(bec_pkg::REG_MODE, 64'(p));
            reg_write(bec_pkg::REG_WEIGHTS, {32'h0, w_hi, w_lo});
            reg_write(bec_pkg::REG_PID, {16'h0, gain16(), gain16(), gain16()});
            reg_write(bec_pkg::REG_STATE, (p == 5) ? 64'hffff_ffff_ffff_ffff
                                          : {gain16(), gain16(), gain16(), gain16()});
            reg_write(bec_pkg::REG_ILIM, (p % 4 == 0) ? 64'd32767 : (p % 4 == 1) ? 64'd0
                                              : 64'($urandom_range(0, 32767)));
            reg_write(bec_pkg::REG_DZONE, (p == 3) ? 64'd32767 : (p % 3 == 0) ? 64'd0
                                          : 64'($urandom_range(0, 600)));
            reg_write(bec_pkg::REG_SHUTOFF, (p == 4) ? 64'd0 : (p % 2 == 1) ? 64'd32767
                                            : 64'($urandom_range(1000, 32767)));
            reg_write(bec_pkg::REG_OFFSET, (p == 6) ? 64'hffff_ffff_ffff_8000
                                 : (p == 7) ? 64'd32767
                                 : {{48{1'b0}}, 16'($urandom_range(0, 1000)) - 16'd500});
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            no_idle = (p % 5 == 2);
            if (p == 9)
                hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(random_sample());
            drain_results();
        end

        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
